@@ rtl/core/qur_pkg.sv @@
// Shared types and constants of the quad ultrasonic echo ranger.
// Used by the front end, the request queue, the back end and the top level.
// No dependencies.
package qur_pkg;

   localparam int CHANNELS    = 4;
   localparam int DIST_W      = 20;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Control bits of one classified request.
   typedef struct packed {
      logic trig;
      logic done;
   } ctl_type;

   // Round control settings seen by the front end.
   typedef struct packed {
      logic        run_enable;
      logic [7:0]  trigger_ticks;
      logic [15:0] rise_timeout;
   } run_cfg_type;

   // Conversion settings seen by the back end.
   typedef struct packed {
      logic [15:0]       scale;
      logic [DIST_W-1:0] max_distance;
   } dist_cfg_type;

endpackage

@@ rtl/core/qur_front.sv @@
// Front end of the echo ranger: the round state machine, run once per request.
// Produces the trigger/done controls and the captured counts of each tick.
// Depends on qur_pkg.
module qur_front #(
   parameter int COUNT_BITS = 16
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          in_valid,
   input  logic [qur_pkg::CHANNELS-1:0]                  echo,
   input  qur_pkg::run_cfg_type                          cfg,
   output qur_pkg::ctl_type                              ctl,
   output logic [qur_pkg::CHANNELS-1:0][COUNT_BITS-1:0] capt
);
   import qur_pkg::*;

   localparam int CNT_W = (COUNT_BITS + 1 > 17) ? COUNT_BITS + 1 : 17;

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_TRIG = 3'd1;
   localparam logic [2:0] PH_RISE = 3'd2;
   localparam logic [2:0] PH_MEAS = 3'd3;
   localparam logic [2:0] PH_LOW  = 3'd4;

   logic [2:0]                             phase_ff, phase_in;
   logic [CNT_W-1:0]                       count_ff, count_in;
   logic [CHANNELS-1:0]                    pending_ff, pending_in;
   logic [CHANNELS-1:0][COUNT_BITS-1:0]   capt_ff, capt_in;
   logic [CNT_W-1:0]                       next_cnt;
   logic [CHANNELS-1:0]                    pend_v;
   logic [7:0]                             tlen;

   assign next_cnt = count_ff + CNT_W'(1);
   assign tlen     = (cfg.trigger_ticks == 8'd0) ? 8'd1 : cfg.trigger_ticks;

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      pending_in = pending_ff;
      capt_in    = capt_ff;
      pend_v     = pending_ff;
      ctl.trig   = 1'b0;
      ctl.done   = 1'b0;
      if (!cfg.run_enable) begin
         phase_in   = PH_IDLE;
         pending_in = '0;
         count_in   = '0;
      end else begin
         case (phase_ff)
            PH_IDLE: begin
               phase_in = PH_TRIG;
               count_in = CNT_W'(1);
               ctl.trig = 1'b1;
            end
            PH_TRIG: begin
               if (count_ff < CNT_W'(tlen)) begin
                  count_in = next_cnt;
                  ctl.trig = 1'b1;
               end else begin
                  phase_in = PH_RISE;
                  count_in = '0;
               end
            end
            PH_RISE: begin
               if (echo == {CHANNELS{1'b1}} || count_ff >= CNT_W'(cfg.rise_timeout)) begin
                  phase_in   = PH_MEAS;
                  count_in   = CNT_W'(1);
                  pending_in = {CHANNELS{1'b1}};
               end else begin
                  count_in = next_cnt;
               end
            end
            PH_MEAS: begin
               for (int i = 0; i < CHANNELS; i++) begin
                  if (pend_v[i] && !echo[i]) begin
                     capt_in[i] = count_ff[COUNT_BITS-1:0];
                     pend_v[i]  = 1'b0;
                  end
               end
               count_in = next_cnt;
               // The counter has wrapped: whatever is still pending times out.
               if (next_cnt[COUNT_BITS]) begin
                  for (int i = 0; i < CHANNELS; i++) begin
                     if (pend_v[i]) begin
                        capt_in[i] = '0;
                     end
                  end
                  pend_v   = '0;
                  count_in = '0;
               end
               if (pend_v == '0) begin
                  ctl.done = 1'b1;
                  phase_in = PH_LOW;
                  count_in = '0;
               end
               pending_in = pend_v;
            end
            PH_LOW: begin
               if (echo == '0) begin
                  phase_in = PH_IDLE;
               end
            end
            default: begin
               phase_in   = PH_IDLE;
               count_in   = '0;
               pending_in = '0;
            end
         endcase
      end
   end

   assign capt = capt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         count_ff   <= '0;
         pending_ff <= '0;
         capt_ff    <= '0;
      end else if (in_valid) begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         pending_ff <= pending_in;
         capt_ff    <= capt_in;
      end
   end

endmodule

@@ rtl/core/qur_fifo.sv @@
// Short request queue between the front end and the back end.
// Register based, first word falls through to the read port.
// Depends on qur_pkg.
module qur_fifo #(
   parameter int WIDTH = 66
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);
   import qur_pkg::*;

   logic [QUEUE_DEPTH-1:0][WIDTH-1:0] mem_ff;
   logic [QPTR_W-1:0]                 wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]                   count_ff;
   logic                              do_wr, do_rd;

   assign full    = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (do_rd) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (do_wr && !do_rd) begin
            count_ff <= count_ff + (QPTR_W + 1)'(1);
         end else if (do_rd && !do_wr) begin
            count_ff <= count_ff - (QPTR_W + 1)'(1);
         end
      end
   end

endmodule

@@ rtl/core/qur_back.sv @@
// Back end of the echo ranger: per-channel scale multiply, range check and
// distance latch, in two pipeline stages with stall control.
// Depends on qur_pkg.
module qur_back #(
   parameter int COUNT_BITS = 16
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic                                               in_valid,
   output logic                                               in_ready,
   input  qur_pkg::ctl_type                                   in_ctl,
   input  logic [qur_pkg::CHANNELS-1:0][COUNT_BITS-1:0]      in_capt,
   input  qur_pkg::dist_cfg_type                              cfg,
   output logic                                               out_valid,
   input  logic                                               out_pop,
   output qur_pkg::ctl_type                                   out_ctl,
   output logic [qur_pkg::CHANNELS-1:0][qur_pkg::DIST_W-1:0] out_dist
);
   import qur_pkg::*;

   localparam int PW = COUNT_BITS + 16;
   localparam int SW = COUNT_BITS + 8;
   localparam int CW = (SW > DIST_W) ? SW : DIST_W;

   logic                              a_valid_ff;
   ctl_type                           a_ctl_ff;
   logic [CHANNELS-1:0][PW-1:0]       a_prod_ff;
   logic                              b_valid_ff;
   ctl_type                           b_ctl_ff;
   logic [CHANNELS-1:0][DIST_W-1:0]   dist_ff;
   logic [CHANNELS-1:0][DIST_W-1:0]   dist_in;
   logic                              a_ready, b_ready;

   assign b_ready  = !b_valid_ff || out_pop;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   // Range check on the shifted product of each lane.
   always_comb begin
      logic [CW-1:0] d_ext;
      for (int i = 0; i < CHANNELS; i++) begin
         d_ext = CW'(a_prod_ff[i][PW-1:8]);
         if (d_ext > CW'(cfg.max_distance)) begin
            dist_in[i] = '0;
         end else begin
            dist_in[i] = d_ext[DIST_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && in_valid) begin
         a_ctl_ff <= in_ctl;
         for (int i = 0; i < CHANNELS; i++) begin
            a_prod_ff[i] <= PW'(in_capt[i]) * PW'(cfg.scale);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         b_ctl_ff   <= '0;
         dist_ff    <= '0;
      end else begin
         if (a_ready) begin
            a_valid_ff <= in_valid;
         end
         if (b_ready) begin
            b_valid_ff <= a_valid_ff;
            if (a_valid_ff) begin
               b_ctl_ff <= a_ctl_ff;
               if (a_ctl_ff.done) begin
                  dist_ff <= dist_in;
               end
            end
         end
      end
   end

   assign out_valid = b_valid_ff;
   assign out_ctl   = b_ctl_ff;
   assign out_dist  = dist_ff;

endmodule

@@ rtl/core/quad_ultrasonic_echo_ranger_unit.sv @@
// Quad ultrasonic echo ranger, one request per timer tick, one result each.
// A result reaches the result ports through the queue write, the multiply stage and
// the output register, in that order, once its request is accepted.
// Throughput: one request per cycle while the queue is not full; results left unpopped stall it.
// Reset: synchronous; settings, pointers and valids return to their defaults, distances read 0.
module quad_ultrasonic_echo_ranger_unit #(
   parameter int COUNT_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [qur_pkg::CHANNELS-1:0]  req_echo,
   output logic                          empty,
   input  logic                          pop,
   output logic                          rsp_trigger,
   output logic                          rsp_done_res,
   output logic [qur_pkg::DIST_W-1:0]    rsp_dist_ch0,
   output logic [qur_pkg::DIST_W-1:0]    rsp_dist_ch1,
   output logic [qur_pkg::DIST_W-1:0]    rsp_dist_ch2,
   output logic [qur_pkg::DIST_W-1:0]    rsp_dist_ch3,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [2:0]                    csr_index,
   input  logic [qur_pkg::DIST_W-1:0]    csr_wdata
);
   import qur_pkg::*;

   localparam logic [2:0] REG_RUN_ENABLE    = 3'd0;
   localparam logic [2:0] REG_TRIGGER_TICKS = 3'd1;
   localparam logic [2:0] REG_RISE_TIMEOUT  = 3'd2;
   localparam logic [2:0] REG_SCALE         = 3'd3;
   localparam logic [2:0] REG_MAX_DISTANCE  = 3'd4;

   localparam int QW = $bits(ctl_type) + CHANNELS * COUNT_BITS;

   run_cfg_type                         run_cfg_ff;
   dist_cfg_type                        dist_cfg_ff;
   logic                                accept;
   ctl_type                             f_ctl;
   logic [CHANNELS-1:0][COUNT_BITS-1:0] f_capt;
   logic [QW-1:0]                       q_wr_data, q_rd_data;
   logic                                q_empty, q_pop;
   ctl_type                             q_ctl;
   logic [CHANNELS-1:0][COUNT_BITS-1:0] q_capt;
   logic                                b_valid;
   ctl_type                             b_ctl;
   logic [CHANNELS-1:0][DIST_W-1:0]     b_dist;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_cfg_ff.run_enable    <= 1'b0;
         run_cfg_ff.trigger_ticks <= 8'd7;
         run_cfg_ff.rise_timeout  <= 16'd51200;
         dist_cfg_ff.scale        <= 16'd1783;
         dist_cfg_ff.max_distance <= 20'd76800;
      end else if (csr_valid) begin
         case (csr_index)
            REG_RUN_ENABLE:    run_cfg_ff.run_enable    <= csr_wdata[0];
            REG_TRIGGER_TICKS: run_cfg_ff.trigger_ticks <= csr_wdata[7:0];
            REG_RISE_TIMEOUT:  run_cfg_ff.rise_timeout  <= csr_wdata[15:0];
            REG_SCALE:         dist_cfg_ff.scale        <= csr_wdata[15:0];
            REG_MAX_DISTANCE:  dist_cfg_ff.max_distance <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign accept = push && !full;

   qur_front #(
      .COUNT_BITS(COUNT_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .echo     (req_echo),
      .cfg      (run_cfg_ff),
      .ctl      (f_ctl),
      .capt     (f_capt)
   );

   assign q_wr_data = {f_ctl, f_capt};

   qur_fifo #(
      .WIDTH(QW)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept),
      .wr_data (q_wr_data),
      .full    (full),
      .rd_en   (q_pop),
      .rd_data (q_rd_data),
      .empty   (q_empty)
   );

   assign {q_ctl, q_capt} = q_rd_data;

   qur_back #(
      .COUNT_BITS(COUNT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (!q_empty),
      .in_ready  (q_pop),
      .in_ctl    (q_ctl),
      .in_capt   (q_capt),
      .cfg       (dist_cfg_ff),
      .out_valid (b_valid),
      .out_pop   (pop),
      .out_ctl   (b_ctl),
      .out_dist  (b_dist)
   );

   assign empty        = !b_valid;
   assign rsp_trigger  = b_ctl.trig;
   assign rsp_done_res = b_ctl.done;
   assign rsp_dist_ch0 = b_dist[0];
   assign rsp_dist_ch1 = b_dist[1];
   assign rsp_dist_ch2 = b_dist[2];
   assign rsp_dist_ch3 = b_dist[3];

endmodule

@@ tb/qur_range_checker.sv @@
`timescale 1ns / 1ps
// Register map of the ranger testbench and the checker that predicts each tick report
// of the ranger and compares it with what the unit returns on its result queue.
// Depends on qur_pkg for the channel count and the distance width.
package qur_tb_pkg;

   typedef enum logic [2:0] {
      REG_RUN_ENABLE    = 3'd0,
      REG_TRIGGER_TICKS = 3'd1,
      REG_RISE_TIMEOUT  = 3'd2,
      REG_SCALE         = 3'd3,
      REG_MAX_DISTANCE  = 3'd4,
      REG_SPARE         = 3'd7
   } csr_reg_e;

endpackage

module qur_range_checker #(
   parameter int COUNT_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic                          full,
   input  logic [qur_pkg::CHANNELS-1:0]  req_echo,
   input  logic                          empty,
   input  logic                          pop,
   input  logic                          rsp_trigger,
   input  logic                          rsp_done_res,
   input  logic [qur_pkg::DIST_W-1:0]    rsp_dist_ch0,
   input  logic [qur_pkg::DIST_W-1:0]    rsp_dist_ch1,
   input  logic [qur_pkg::DIST_W-1:0]    rsp_dist_ch2,
   input  logic [qur_pkg::DIST_W-1:0]    rsp_dist_ch3,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [2:0]                    csr_index,
   input  logic [qur_pkg::DIST_W-1:0]    csr_wdata,
   output int                            reports_due,
   output int                            mismatches
);
   import qur_pkg::*;
   import qur_tb_pkg::*;

   localparam int TICK_W = COUNT_BITS + 1;
   localparam int PROD_W = COUNT_BITS + 16;
   localparam logic [TICK_W-1:0] COUNT_WRAP = TICK_W'(1) << COUNT_BITS;

   localparam logic [7:0]        PULSE_LEN_RST   = 8'd7;
   localparam logic [15:0]       RISE_LIMIT_RST  = 16'd51200;
   localparam logic [15:0]       CM_PER_TICK_RST = 16'd1783;
   localparam logic [DIST_W-1:0] RANGE_LIMIT_RST = 20'd76800;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_TRIGGER,
      PH_RISE_WAIT,
      PH_MEASURE,
      PH_WAIT_LOW
   } round_phase_e;

   typedef struct packed {
      logic                            trigger;
      logic                            done_res;
      logic [CHANNELS-1:0][DIST_W-1:0] range_q8;
   } tick_report_t;

   tick_report_t tick_reports_q[$];

   logic                  cfg_running;
   logic [7:0]            cfg_pulse_len;
   logic [15:0]           cfg_rise_limit;
   logic [15:0]           cfg_cm_per_tick;
   logic [DIST_W-1:0]     cfg_range_limit;

   round_phase_e          stage;
   logic [TICK_W-1:0]     ticks;
   logic [CHANNELS-1:0]   armed;
   logic [COUNT_BITS-1:0] echo_time [CHANNELS];
   logic [DIST_W-1:0]     range_cm  [CHANNELS];

   function automatic logic [DIST_W-1:0] echo_to_range(input logic [COUNT_BITS-1:0] t);
      logic [PROD_W-1:0] product;
      product = (PROD_W'(t) * PROD_W'(cfg_cm_per_tick)) >> 8;
      if (product > PROD_W'(cfg_range_limit)) return '0;
      return product[DIST_W-1:0];
   endfunction

   // Advances the round by one timer tick and returns the report of that tick.
   task automatic predict_report(input logic [CHANNELS-1:0] lvl, output tick_report_t rpt);
      logic [7:0] pulse_len;
      pulse_len = (cfg_pulse_len == 8'd0) ? 8'd1 : cfg_pulse_len;
      rpt = '0;
      if (!cfg_running) begin
         stage = PH_IDLE;
         armed = '0;
         ticks = '0;
      end else begin
         case (stage)
            PH_IDLE: begin
               stage = PH_TRIGGER;
               ticks = TICK_W'(1);
               rpt.trigger = 1'b1;
            end
            PH_TRIGGER: begin
               if (ticks < TICK_W'(pulse_len)) begin
                  ticks = ticks + TICK_W'(1);
                  rpt.trigger = 1'b1;
               end else begin
                  stage = PH_RISE_WAIT;
                  ticks = '0;
               end
            end
            PH_RISE_WAIT: begin
               if (&lvl || ticks >= TICK_W'(cfg_rise_limit)) begin
                  stage = PH_MEASURE;
                  ticks = TICK_W'(1);
                  armed = '1;
               end else begin
                  ticks = ticks + TICK_W'(1);
               end
            end
            PH_MEASURE: begin
               for (int ch = 0; ch < CHANNELS; ch++) begin
                  if (armed[ch] && !lvl[ch]) begin
                     echo_time[ch] = ticks[COUNT_BITS-1:0];
                     armed[ch] = 1'b0;
                  end
               end
               ticks = ticks + TICK_W'(1);
               // A counter wrap gives up on every channel still waiting.
               if (ticks >= COUNT_WRAP) begin
                  for (int ch = 0; ch < CHANNELS; ch++) begin
                     if (armed[ch]) echo_time[ch] = '0;
                  end
                  armed = '0;
                  ticks = '0;
               end
               if (armed == '0) begin
                  for (int ch = 0; ch < CHANNELS; ch++) begin
                     range_cm[ch] = echo_to_range(echo_time[ch]);
                  end
                  rpt.done_res = 1'b1;
                  stage = PH_WAIT_LOW;
                  ticks = '0;
               end
            end
            PH_WAIT_LOW: begin
               if (lvl == '0) stage = PH_IDLE;
            end
            default: begin
               stage = PH_IDLE;
               ticks = '0;
               armed = '0;
            end
         endcase
      end
      for (int ch = 0; ch < CHANNELS; ch++) begin
         rpt.range_q8[ch] = range_cm[ch];
      end
   endtask

   always @(posedge clock) begin
      tick_report_t want;
      tick_report_t got;
      int           bad;
      int           due;
      bad = 0;
      due = reports_due;
      if (reset) begin
         cfg_running     = 1'b0;
         cfg_pulse_len   = PULSE_LEN_RST;
         cfg_rise_limit  = RISE_LIMIT_RST;
         cfg_cm_per_tick = CM_PER_TICK_RST;
         cfg_range_limit = RANGE_LIMIT_RST;
         stage = PH_IDLE;
         ticks = '0;
         armed = '0;
         for (int ch = 0; ch < CHANNELS; ch++) begin
            echo_time[ch] = '0;
            range_cm[ch]  = '0;
         end
         tick_reports_q.delete();
         due = 0;
         mismatches <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_RUN_ENABLE:    cfg_running     = csr_wdata[0];
               REG_TRIGGER_TICKS: cfg_pulse_len   = csr_wdata[7:0];
               REG_RISE_TIMEOUT:  cfg_rise_limit  = csr_wdata[15:0];
               REG_SCALE:         cfg_cm_per_tick = csr_wdata[15:0];
               REG_MAX_DISTANCE:  cfg_range_limit = csr_wdata;
               default: ;
            endcase
         end
         // A request passes through registers in the unit before its report can be popped, so a report popped at
         // this edge can never belong to a request pushed at the same edge.
         if (pop && !empty) begin
            got.trigger     = rsp_trigger;
            got.done_res    = rsp_done_res;
            got.range_q8[0] = rsp_dist_ch0;
            got.range_q8[1] = rsp_dist_ch1;
            got.range_q8[2] = rsp_dist_ch2;
            got.range_q8[3] = rsp_dist_ch3;
            if (tick_reports_q.size() == 0) begin
               $error("tick report with no request waiting: trigger %0d, done_res %0d",
                      got.trigger, got.done_res);
               bad++;
            end else begin
               want = tick_reports_q.pop_front();
               due--;
               if (got.trigger !== want.trigger) begin
                  $error("trigger: expected %0d, actual %0d", want.trigger, got.trigger);
                  bad++;
               end
               if (got.done_res !== want.done_res) begin
                  $error("done_res: expected %0d, actual %0d", want.done_res, got.done_res);
                  bad++;
               end
               for (int ch = 0; ch < CHANNELS; ch++) begin
                  if (got.range_q8[ch] !== want.range_q8[ch]) begin
                     $error("dist_ch%0d: expected %0d, actual %0d",
                            ch, want.range_q8[ch], got.range_q8[ch]);
                     bad++;
                  end
               end
            end
         end
         if (push && !full) begin
            predict_report(req_echo, want);
            tick_reports_q.push_back(want);
            due++;
         end
         mismatches <= mismatches + bad;
      end
      reports_due <= due;
   end

endmodule

@@ tb/tb_quad_ultrasonic_echo_ranger_unit.sv @@
`timescale 1ns / 1ps
// Top of the ranger testbench: clock, reset, tick requests, register writes and verdict.
// Depends on qur_pkg, on qur_tb_pkg and qur_range_checker, and on the unit itself.
module tb_quad_ultrasonic_echo_ranger_unit;
   import qur_pkg::*;
   import qur_tb_pkg::*;

   localparam int COUNT_BITS = 16;

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                push      = 1'b0;
   logic [CHANNELS-1:0] req_echo  = '0;
   logic                pop       = 1'b0;
   logic                csr_valid = 1'b0;
   logic [2:0]          csr_index = '0;
   logic [DIST_W-1:0]   csr_wdata = '0;

   logic                full;
   logic                empty;
   logic                rsp_trigger;
   logic                rsp_done_res;
   logic [DIST_W-1:0]   rsp_dist_ch0;
   logic [DIST_W-1:0]   rsp_dist_ch1;
   logic [DIST_W-1:0]   rsp_dist_ch2;
   logic [DIST_W-1:0]   rsp_dist_ch3;
   logic                csr_ready;

   int                  reports_due;
   int                  mismatches;

   // While set, neither side of the unit idles.
   bit                  steady = 1'b0;
   int unsigned         ticks_sent = 0;
   logic [7:0]          pulse_len  = 8'd7;
   logic [15:0]         rise_limit = 16'd51200;

   quad_ultrasonic_echo_ranger_unit #(
      .COUNT_BITS(COUNT_BITS)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .req_echo     (req_echo),
      .empty        (empty),
      .pop          (pop),
      .rsp_trigger  (rsp_trigger),
      .rsp_done_res (rsp_done_res),
      .rsp_dist_ch0 (rsp_dist_ch0),
      .rsp_dist_ch1 (rsp_dist_ch1),
      .rsp_dist_ch2 (rsp_dist_ch2),
      .rsp_dist_ch3 (rsp_dist_ch3),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   qur_range_checker #(
      .COUNT_BITS(COUNT_BITS)
   ) range_check (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .req_echo     (req_echo),
      .empty        (empty),
      .pop          (pop),
      .rsp_trigger  (rsp_trigger),
      .rsp_done_res (rsp_done_res),
      .rsp_dist_ch0 (rsp_dist_ch0),
      .rsp_dist_ch1 (rsp_dist_ch1),
      .rsp_dist_ch2 (rsp_dist_ch2),
      .rsp_dist_ch3 (rsp_dist_ch3),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .reports_due  (reports_due),
      .mismatches   (mismatches)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         pop <= steady || ($urandom_range(99) >= 37);
      end
   end

   task automatic send_tick(input logic [CHANNELS-1:0] lvl);
      while (!steady && $urandom_range(99) < 37) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push     <= 1'b1;
      req_echo <= lvl;
      @(posedge clock);
      while (full) @(posedge clock);
      ticks_sent++;
   endtask

   task automatic hold_until_drained();
      push <= 1'b0;
      @(posedge clock);
      while (reports_due != 0) @(posedge clock);
   endtask

   task automatic write_reg(input csr_reg_e idx, input logic [DIST_W-1:0] value);
      logic [DIST_W-1:0] keep;
      case (idx)
         REG_RUN_ENABLE:              keep = 20'h00001;
         REG_TRIGGER_TICKS:           keep = 20'h000FF;
         REG_RISE_TIMEOUT, REG_SCALE: keep = 20'h0FFFF;
         default:                     keep = '1;
      endcase
      // Junk above the field width has to be dropped by the unit.
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= (value & keep) | (DIST_W'($urandom) & ~keep);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_regs(input logic run, input logic [7:0] pulse,
                               input logic [15:0] rise, input logic [15:0] cm_per_tick,
                               input logic [DIST_W-1:0] limit);
      hold_until_drained();
      write_reg(REG_TRIGGER_TICKS, DIST_W'(pulse));
      write_reg(REG_RISE_TIMEOUT, DIST_W'(rise));
      write_reg(REG_SCALE, DIST_W'(cm_per_tick));
      write_reg(REG_MAX_DISTANCE, limit);
      write_reg(REG_RUN_ENABLE, DIST_W'(run));
      pulse_len  = pulse;
      rise_limit = rise;
   endtask

   // One sensor-like round: quiet while the trigger runs, all echoes high
   // together for at least one tick, each falling after its own width, then
   // quiet again. A deaf channel never rises, so the rise wait has to time
   // out. The round stops early after cut ticks.
   task automatic echo_round(input int unsigned max_width, input bit deaf,
                             input int unsigned cut);
      int unsigned         lead;
      int unsigned         span;
      int unsigned         t;
      int unsigned         deaf_ch;
      int unsigned         rise_at [CHANNELS];
      int unsigned         fall_at [CHANNELS];
      logic [CHANNELS-1:0] lvl;
      lead    = pulse_len + 2 + $urandom_range(3);
      deaf_ch = $urandom_range(CHANNELS - 1);
      span    = 0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         rise_at[ch] = lead + $urandom_range(2);
         fall_at[ch] = lead + 3 + $urandom_range(max_width) + (deaf ? rise_limit : 0);
         if (deaf && ch == deaf_ch) fall_at[ch] = rise_at[ch];
         if (fall_at[ch] > span) span = fall_at[ch];
      end
      span = span + 1 + $urandom_range(3);
      if (cut < span) span = cut;
      for (t = 0; t < span; t++) begin
         for (int ch = 0; ch < CHANNELS; ch++) begin
            lvl[ch] = (t >= rise_at[ch]) && (t < fall_at[ch]);
         end
         send_tick(lvl);
      end
   endtask

   // Mostly well-formed rounds; the rest are cut-off rounds, some followed by
   // a disable in the middle of the round, raw noise and full drains.
   task automatic random_rounds(input int unsigned budget, input int unsigned max_width);
      int unsigned stop;
      int unsigned pick;
      int unsigned width;
      bit          deaf;
      stop = ticks_sent + budget;
      while (ticks_sent < stop) begin
         pick  = $urandom_range(99);
         width = ($urandom_range(9) == 0) ? 300 : max_width;
         deaf  = (rise_limit <= 16'd64) && ($urandom_range(9) == 0);
         if (pick < 70) begin
            echo_round(width, deaf, 32'hFFFF_FFFF);
         end else if (pick < 82) begin
            echo_round(width, deaf, $urandom_range(24, 1));
            if ($urandom_range(2) == 0) begin
               hold_until_drained();
               write_reg(REG_RUN_ENABLE, 20'd0);
               repeat ($urandom_range(3, 1)) send_tick(CHANNELS'($urandom));
               hold_until_drained();
               write_reg(REG_RUN_ENABLE, 20'd1);
            end
         end else if (pick < 92) begin
            repeat ($urandom_range(10, 1)) send_tick(CHANNELS'($urandom));
         end else begin
            hold_until_drained();
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // While disabled the unit only reports idle ticks.
      send_tick(4'hF);
      send_tick(4'h0);
      hold_until_drained();
      write_reg(REG_SPARE, DIST_W'($urandom));

      // Shortest trigger and no rise wait; channels 0 and 2 fall first, then 1, then 3.
      program_regs(1'b1, 8'd0, 16'd0, 16'hFFFF, 20'hFFFFF);
      send_tick(4'b0000);
      send_tick(4'b0000);
      send_tick(4'b0000);
      send_tick(4'b1010);
      send_tick(4'b1000);
      send_tick(4'b0111);
      send_tick(4'b0000);

      // Disable in the middle of a trigger pulse, then one ordinary round.
      program_regs(1'b1, 8'd3, 16'd51200, 16'd1783, 20'd76800);
      send_tick(4'b0000);
      send_tick(4'b0000);
      hold_until_drained();
      write_reg(REG_RUN_ENABLE, 20'd0);
      send_tick(4'b1111);
      hold_until_drained();
      write_reg(REG_RUN_ENABLE, 20'd1);
      echo_round(20, 1'b0, 32'hFFFF_FFFF);

      program_regs(1'b1, 8'd7, 16'd51200, 16'd1783, 20'd76800);
      random_rounds(200, 40);

      steady <= 1'b1;
      program_regs(1'b1, 8'd1, 16'd5, 16'hFFFF, 20'hFFFFF);
      random_rounds(200, 30);
      hold_until_drained();
      steady <= 1'b0;

      program_regs(1'b1, 8'd0, 16'd0, 16'd0, 20'd0);
      random_rounds(150, 20);

      program_regs(1'b1, 8'd255, 16'hFFFF, 16'd40000, 20'd3000);
      random_rounds(250, 60);

      repeat (3) begin
         program_regs(1'b1, 8'($urandom_range(12, 1)), 16'($urandom_range(40, 1)),
                      16'($urandom), DIST_W'($urandom));
         random_rounds(80, 50);
      end

      hold_until_drained();
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("[quad_ultrasonic_echo_ranger_unit] OK");
      end else begin
         $display("[quad_ultrasonic_echo_ranger_unit] ERROR");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("[quad_ultrasonic_echo_ranger_unit] ERROR");
      $finish;
   end

endmodule
